// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the transform engine, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent true implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/m4te_pkg.sv
// ----------------------------------------------------------------------------
// m4te_pkg
// Shared constants, request codes and word types of the 4x4 transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

package m4te_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM           = 4;
    localparam int DW            = 32;

    localparam logic [1:0] REQ_WR_CUR  = 2'd0;
    localparam logic [1:0] REQ_WR_OPD  = 2'd1;
    localparam logic [1:0] REQ_COMPOSE = 2'd2;
    localparam logic [1:0] REQ_APPLY   = 2'd3;

    typedef logic signed [DW-1:0] t_word;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] row_index;
        logic [1:0] col_index;
        t_word      elem_value;
        t_word      in_x;
        t_word      in_y;
        t_word      in_z;
        t_word      in_w;
    } t_req;

    typedef struct packed {
        t_word out_x;
        t_word out_y;
        t_word out_z;
        t_word out_w;
        logic  saturated;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/m4te_front.sv
// ----------------------------------------------------------------------------
// m4te_front
// Request front end: two-word queue that accepts request words and hands
// them in order to the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module m4te_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  m4te_pkg::t_req  i_req,
    output logic            o_req_valid,
    output m4te_pkg::t_req  o_req,
    input  logic            i_req_take
);
    import m4te_pkg::*;

    t_req       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_take;

    assign full        = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_mem[r_rd];
    assign w_push      = push && !full;
    assign w_take      = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

`default_nettype wire

// File: rtl/m4te_back.sv
// ----------------------------------------------------------------------------
// m4te_back
// Execution unit: holds both matrices, runs element writes, compose and
// point transform through four shared multipliers and a sum/saturate pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module m4te_back #(
    parameter int FRAC_BITS = m4te_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  m4te_pkg::t_req  i_req,
    output logic            o_req_take,
    input  logic            i_res_full,
    output logic            o_res_push,
    output m4te_pkg::t_res  o_res
);
    import m4te_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_APPLY   = 2'd1;
    localparam logic [1:0] ST_COMPOSE = 2'd2;
    localparam logic [1:0] ST_DRAIN   = 2'd3;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    logic [1:0]         r_st;
    logic [1:0]         n_st;
    logic [3:0]         r_idx;
    logic [3:0]         n_idx;
    logic               r_is_apply;
    t_word              r_cur [DIM][DIM];
    t_word              r_opc [DIM][DIM];
    t_word              r_pt  [DIM];
    t_word              r_rb  [DIM];
    t_word              r_out [DIM];
    logic               r_sat;
    logic signed [63:0] r_p   [DIM];
    logic signed [64:0] r_s   [2];
    logic               r_v1;
    logic               r_v2;
    logic [3:0]         r_t1;
    logic [3:0]         r_t2;

    logic               w_issue;
    logic [1:0]         w_row;
    logic [1:0]         w_col;
    t_word              w_a [DIM];
    t_word              w_b [DIM];
    logic signed [65:0] w_tot;
    logic signed [65:0] w_sh;
    t_word              w_val;
    logic               w_clip;
    logic               w_start_apply;
    logic               w_start_comp;
    logic               w_done;

    assign w_issue = (r_st == ST_APPLY) || (r_st == ST_COMPOSE);
    assign w_row   = (r_st == ST_APPLY) ? r_idx[1:0] : r_idx[3:2];
    assign w_col   = r_idx[1:0];
    assign w_done  = (r_st == ST_DRAIN) && !r_v1 && !r_v2;

    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            w_a[k] = r_cur[w_row][k];
            w_b[k] = (r_st == ST_APPLY) ? r_pt[k] : r_opc[w_col][k];
        end
    end

    assign w_tot = 66'(r_s[0]) + 66'(r_s[1]);
    assign w_sh  = w_tot >>> FRAC_BITS;

    always_comb begin
        if (w_sh > SAT_MAX) begin
            w_val  = SAT_MAX[DW-1:0];
            w_clip = 1'b1;
        end else if (w_sh < SAT_MIN) begin
            w_val  = SAT_MIN[DW-1:0];
            w_clip = 1'b1;
        end else begin
            w_val  = w_sh[DW-1:0];
            w_clip = 1'b0;
        end
    end

    always_comb begin
        n_st          = r_st;
        n_idx         = r_idx;
        o_req_take    = 1'b0;
        w_start_apply = 1'b0;
        w_start_comp  = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req.req_type)
                        REQ_WR_CUR, REQ_WR_OPD: begin
                            o_req_take = 1'b1;
                        end
                        REQ_COMPOSE: begin
                            o_req_take   = 1'b1;
                            w_start_comp = 1'b1;
                            n_st         = ST_COMPOSE;
                            n_idx        = 4'd0;
                        end
                        REQ_APPLY: begin
                            if (!i_res_full) begin
                                o_req_take    = 1'b1;
                                w_start_apply = 1'b1;
                                n_st          = ST_APPLY;
                                n_idx         = 4'd0;
                            end
                        end
                        default: begin
                            o_req_take = 1'b0;
                        end
                    endcase
                end
            end
            ST_APPLY: begin
                n_idx = r_idx + 4'd1;
                if (r_idx[1:0] == 2'd3) begin
                    n_st = ST_DRAIN;
                end
            end
            ST_COMPOSE: begin
                n_idx = r_idx + 4'd1;
                if (r_idx == 4'd15) begin
                    n_st = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_done) begin
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_idx      <= 4'd0;
            r_is_apply <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            r_st <= n_st;
            r_idx <= n_idx;
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (w_start_apply) begin
                r_is_apply <= 1'b1;
            end else if (w_start_comp) begin
                r_is_apply <= 1'b0;
            end
        end
    end

    // hold the matrices; clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_cur[r][c] <= '0;
                    r_opc[r][c] <= '0;
                end
            end
        end else begin
            if (o_req_take && (i_req.req_type == REQ_WR_CUR)) begin
                r_cur[i_req.row_index][i_req.col_index] <= i_req.elem_value;
            end
            if (o_req_take && (i_req.req_type == REQ_WR_OPD)) begin
                r_opc[i_req.col_index][i_req.row_index] <= i_req.elem_value;
            end
            if (r_v2 && !r_is_apply && (r_t2[1:0] == 2'd3)) begin
                r_cur[r_t2[3:2]][0] <= r_rb[0];
                r_cur[r_t2[3:2]][1] <= r_rb[1];
                r_cur[r_t2[3:2]][2] <= r_rb[2];
                r_cur[r_t2[3:2]][3] <= w_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_apply) begin
            r_pt[0] <= i_req.in_x;
            r_pt[1] <= i_req.in_y;
            r_pt[2] <= i_req.in_z;
            r_pt[3] <= i_req.in_w;
            r_sat   <= 1'b0;
        end else if (r_v2 && r_is_apply) begin
            r_sat <= r_sat | w_clip;
        end
        for (int k = 0; k < DIM; k++) begin
            r_p[k] <= 64'(w_a[k]) * 64'(w_b[k]);
        end
        r_t1   <= r_idx;
        r_t2   <= r_t1;
        r_s[0] <= 65'(r_p[0]) + 65'(r_p[1]);
        r_s[1] <= 65'(r_p[2]) + 65'(r_p[3]);
        if (r_v2) begin
            if (r_is_apply) begin
                r_out[r_t2[1:0]] <= w_val;
            end else begin
                r_rb[r_t2[1:0]] <= w_val;
            end
        end
    end

    assign o_res_push      = w_done && r_is_apply;
    assign o_res.out_x     = r_out[0];
    assign o_res.out_y     = r_out[1];
    assign o_res.out_z     = r_out[2];
    assign o_res.out_w     = r_out[3];
    assign o_res.saturated = r_sat;

endmodule

`default_nettype wire

// File: rtl/m4te_outq.sv
// ----------------------------------------------------------------------------
// m4te_outq
// Result queue: two-word buffer between the execution unit and the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module m4te_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  m4te_pkg::t_res  i_res,
    output logic            o_full,
    output logic            empty,
    input  logic            pop,
    output m4te_pkg::t_res  o_res
);
    import m4te_pkg::*;

    t_res       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_res  = r_mem[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/matrix4_transform_engine.sv
// ----------------------------------------------------------------------------
// matrix4_transform_engine
// 4x4 homogeneous transform engine, signed Q16.16.
//
// Request channel: push/full. A word is taken when push is high and full is
// low; req_type selects element write (current or operand), compose or
// point apply. A two-word queue holds requests ahead of the execution unit.
// Result channel: empty/pop. Only point apply returns a word; it sits on the
// o_out_* ports while empty is low and leaves on pop. A two-word result
// queue decouples the reader.
// Execution: element writes complete when taken; point apply issues four
// output rows and compose sixteen elements through four shared 32x32
// multipliers and a registered sum/saturate pipe; one request at a time.
// Reset clears both matrices to zero and empties both queues.
// A stalled reader fills the result queue; apply then waits, and the request
// queue backs up into full.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_transform_engine #(
    parameter int FRAC_BITS = m4te_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_row_index,
    input  logic [1:0]          i_col_index,
    input  logic signed [31:0]  i_elem_value,
    input  logic signed [31:0]  i_in_x,
    input  logic signed [31:0]  i_in_y,
    input  logic signed [31:0]  i_in_z,
    input  logic signed [31:0]  i_in_w,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_out_w,
    output logic                o_saturated
);
    import m4te_pkg::*;

`include "assert_macros.svh"

    t_req w_in_req;
    t_req w_req;
    logic w_req_valid;
    logic w_req_take;
    logic w_res_push;
    logic w_outq_full;
    t_res w_res;
    t_res w_out;

    assign w_in_req.req_type   = i_req_type;
    assign w_in_req.row_index  = i_row_index;
    assign w_in_req.col_index  = i_col_index;
    assign w_in_req.elem_value = i_elem_value;
    assign w_in_req.in_x       = i_in_x;
    assign w_in_req.in_y       = i_in_y;
    assign w_in_req.in_z       = i_in_z;
    assign w_in_req.in_w       = i_in_w;

    m4te_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (w_in_req),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_take  (w_req_take)
    );

    m4te_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_take  (w_req_take),
        .i_res_full  (w_outq_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    m4te_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_outq_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_out)
    );

    assign o_out_x     = w_out.out_x;
    assign o_out_y     = w_out.out_y;
    assign o_out_z     = w_out.out_z;
    assign o_out_w     = w_out.out_w;
    assign o_saturated = w_out.saturated;

    `ASSERT_SAME(a_res_no_overflow, w_res_push, !w_outq_full)
    `ASSERT_SAME(a_take_needs_valid, w_req_take, w_req_valid)
    `ASSERT_NEXT(a_res_push_single, w_res_push, !w_res_push)

endmodule

`default_nettype wire

// File: tb/sv/tb_matrix4_transform_engine.sv
// ----------------------------------------------------------------------------
// tb_matrix4_transform_engine
// Self-checking bench for the 4x4 Q16.16 transform engine: element writes,
// compose and point apply, predicted at full width with floor shift and
// saturation, under random push and pop idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix4_transform_engine;

    import m4te_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int N_RANDOM = 400;

    class transform_scoreboard;
        t_word cur_mat[DIM*DIM];
        t_word opd_mat[DIM*DIM];
        t_res  expected_q[$];
        int    mismatches;
        int    checked;
        int    composes;

        function new();
            foreach (cur_mat[i]) begin
                cur_mat[i] = '0;
                opd_mat[i] = '0;
            end
            mismatches = 0;
            checked    = 0;
            composes   = 0;
        endfunction

        function t_word dot_sat(t_word a[DIM], t_word b[DIM], ref bit sat);
            logic signed [65:0] acc;
            logic signed [65:0] sh;
            logic signed [63:0] prod;
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
                prod = 64'(a[k]) * 64'(b[k]);
                acc  = acc + 66'(prod);
            end
            sh = acc >>> FRAC;
            if (sh > 66'sd2147483647) begin
                sat = 1'b1;
                return 32'sh7fffffff;
            end
            if (sh < -66'sd2147483648) begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return sh[31:0];
        endfunction

        function void note_word(t_req r);
            t_word row[DIM];
            t_word col[DIM];
            t_word nxt[DIM*DIM];
            t_res  res;
            bit    sat;
            bit    dummy;
            case (r.req_type)
                REQ_WR_CUR: cur_mat[r.row_index*DIM + r.col_index] = r.elem_value;
                REQ_WR_OPD: opd_mat[r.row_index*DIM + r.col_index] = r.elem_value;
                REQ_COMPOSE: begin
                    composes++;
                    for (int i = 0; i < DIM; i++) begin
                        for (int j = 0; j < DIM; j++) begin
                            for (int k = 0; k < DIM; k++) begin
                                row[k] = cur_mat[i*DIM + k];
                                col[k] = opd_mat[k*DIM + j];
                            end
                            dummy = 1'b0;
                            nxt[i*DIM + j] = dot_sat(row, col, dummy);
                        end
                    end
                    cur_mat = nxt;
                end
                default: begin
                    sat = 1'b0;
                    col[0] = r.in_x;
                    col[1] = r.in_y;
                    col[2] = r.in_z;
                    col[3] = r.in_w;
                    for (int k = 0; k < DIM; k++) row[k] = cur_mat[k];
                    res.out_x = dot_sat(row, col, sat);
                    for (int k = 0; k < DIM; k++) row[k] = cur_mat[DIM + k];
                    res.out_y = dot_sat(row, col, sat);
                    for (int k = 0; k < DIM; k++) row[k] = cur_mat[2*DIM + k];
                    res.out_z = dot_sat(row, col, sat);
                    for (int k = 0; k < DIM; k++) row[k] = cur_mat[3*DIM + k];
                    res.out_w = dot_sat(row, col, sat);
                    res.saturated = sat;
                    expected_q.push_back(res);
                end
            endcase
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
        endtask

        task check_word(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
            if (got.out_w !== want.out_w) report_mismatch("out_w", got.out_w, want.out_w);
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", got.saturated, want.saturated);
            checked++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_req_type = '0;
    logic [1:0]         i_row_index = '0;
    logic [1:0]         i_col_index = '0;
    logic signed [31:0] i_elem_value = '0;
    logic signed [31:0] i_in_x = '0;
    logic signed [31:0] i_in_y = '0;
    logic signed [31:0] i_in_z = '0;
    logic signed [31:0] i_in_w = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_out_w;
    logic               o_saturated;

    transform_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;

    always #5 i_clk = ~i_clk;

    matrix4_transform_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_req_type(i_req_type), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_elem_value(i_elem_value), .i_in_x(i_in_x), .i_in_y(i_in_y),
        .i_in_z(i_in_z), .i_in_w(i_in_w), .empty(empty), .pop(pop),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z), .o_out_w(o_out_w),
        .o_saturated(o_saturated)
    );

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && pop && !empty) begin
            got.out_x = o_out_x;
            got.out_y = o_out_y;
            got.out_z = o_out_z;
            got.out_w = o_out_w;
            got.saturated = o_saturated;
            sb.check_word(got);
        end
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_req_type   <= r.req_type;
        i_row_index  <= r.row_index;
        i_col_index  <= r.col_index;
        i_elem_value <= r.elem_value;
        i_in_x       <= r.in_x;
        i_in_y       <= r.in_y;
        i_in_z       <= r.in_z;
        i_in_w       <= r.in_w;
        do @(posedge i_clk); while (full);
        sb.note_word(r);
        words_sent++;
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            3: return 32'sh80000000;
            4: return 32'sh7fffffff;
            default: return $signed($urandom_range(0, 4)) * 32'sh10000 - 32'sh20000;
        endcase
    endfunction

    function automatic t_req make_word(logic [1:0] kind, int row, int col, t_word v);
        t_req r;
        r.req_type   = kind;
        r.row_index  = 2'(row);
        r.col_index  = 2'(col);
        r.elem_value = v;
        r.in_x = $urandom;
        r.in_y = $urandom;
        r.in_z = $urandom;
        r.in_w = $urandom;
        return r;
    endfunction

    function automatic t_req make_apply(t_word x, t_word y, t_word z, t_word w);
        t_req r;
        r = make_word(REQ_APPLY, $urandom_range(3), $urandom_range(3), $urandom);
        r.in_x = x;
        r.in_y = y;
        r.in_z = z;
        r.in_w = w;
        return r;
    endfunction

    task automatic drain();
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_random(int n_words);
        int sent;
        t_req r;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 70) begin
                repeat ($urandom_range(1, 6)) begin
                    r = make_word($urandom_range(1) ? REQ_WR_CUR : REQ_WR_OPD,
                                  $urandom_range(3), $urandom_range(3), pick_value());
                    send_word(r);
                    sent++;
                end
                if ($urandom_range(99) < 30) begin
                    send_word(make_word(REQ_COMPOSE, $urandom_range(3),
                                        $urandom_range(3), $urandom));
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_word(make_apply(pick_value(), pick_value(), pick_value(),
                                         pick_value()));
                    sent++;
                end
            end else begin
                r = make_word(2'($urandom_range(3)), $urandom_range(3), $urandom_range(3),
                              $urandom);
                send_word(r);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_apply(32'sh10000, 32'sh7fffffff, 32'sh80000000, -32'sd1));
        send_word(make_word(REQ_WR_CUR, 0, 0, 32'sh7fffffff));
        send_word(make_word(REQ_WR_CUR, 1, 1, 32'sh80000000));
        send_word(make_word(REQ_WR_CUR, 2, 3, -32'sd1));
        send_word(make_word(REQ_WR_CUR, 3, 3, 32'sh10000));
        send_word(make_word(REQ_WR_CUR, 3, 0, 32'sh8000));
        send_word(make_word(REQ_WR_OPD, 0, 0, 32'sh20000));
        send_word(make_word(REQ_WR_OPD, 1, 1, 32'sh10000));
        send_word(make_word(REQ_WR_OPD, 3, 3, 32'sh7fffffff));
        send_word(make_word(REQ_WR_OPD, 2, 3, 32'sh80000000));
        send_word(make_apply(32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sh7fffffff));
        send_word(make_apply(32'sh10000, -32'sh10000, 32'sh1, -32'sd3));
        send_word(make_apply(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_word(make_apply(32'sh0, 32'sh1, -32'sd1, 32'sh0));
        send_word(make_word(REQ_COMPOSE, 3, 3, 32'sh7fffffff));
        send_word(make_apply(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
        send_word(make_apply(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
        send_word(make_word(REQ_COMPOSE, 0, 0, 32'sh0));
        send_word(make_apply(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        drain();

        send_idle_pct = 24;
        recv_idle_pct = 69;
        run_random(N_RANDOM / 3);
        drain();
        send_idle_pct = 69;
        recv_idle_pct = 24;
        run_random(N_RANDOM / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(N_RANDOM / 3);
        drain();

        $display("sent %0d words, checked %0d transformed points, %0d compositions",
                 words_sent, sb.checked, sb.composes);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
